// ----- rtl/core/vfm_pkg.sv -----
package vfm_pkg;

    localparam int MAX_VALUES = 32;
    localparam int SAMPLE_W   = 16;
    localparam int OCC_W      = 6;
    localparam int CNT_W      = $clog2(MAX_VALUES + 1);
    localparam int IDX_W      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_VALUES);
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_CAPT = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_EMIT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_MEAN = 7'b1000000
    } state_t;

    typedef struct packed {
        logic take_beat;
        logic load_i;
        logic capture_cur;
        logic scan;
        logic emit_freq;
        logic next_i;
        logic div_start;
        logic div_step;
        logic emit_mean;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic last_j;
        logic last_i;
        logic seen;
        logic out_free;
        logic div_done;
    } sts_t;

endpackage

// ----- rtl/core/value_frequency_and_mean_unit.sv -----
// channel  | direction | handshake          | payload
// in       | sink      | in_valid/in_stall   | sample, final_item
// out      | source    | out_valid/out_stall | is_mean, distinct_value, occurrences,
//          |           |                     | average, dropped, end_of_run
//
// values go one per cycle into the store while in_stall is low and the store is not full
// the final beat starts the count walk over the n stored values through the single store
// read port, then the bit-serial divider
// in_stall stays high from the final beat until the mean beat is loaded
// the output register lets the next run start while the mean beat waits
// reset clears the count, sum, overflow flag, controller and output valid
module value_frequency_and_mean_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [vfm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                final_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_mean,
    output logic signed [vfm_pkg::SAMPLE_W-1:0] distinct_value,
    output logic        [vfm_pkg::OCC_W-1:0]    occurrences,
    output logic signed [vfm_pkg::SAMPLE_W-1:0] average,
    output logic                                dropped,
    output logic                                end_of_run
);
    import vfm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    vfm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_item (final_item),
        .in_stall   (in_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    vfm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .sample         (sample),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .is_mean        (is_mean),
        .distinct_value (distinct_value),
        .occurrences    (occurrences),
        .average        (average),
        .dropped        (dropped),
        .end_of_run     (end_of_run)
    );

endmodule

// ----- rtl/core/vfm_ram.sv -----
module vfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/vfm_ctrl.sv -----
module vfm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          final_item,
    output logic          in_stall,
    input  vfm_pkg::sts_t sts,
    output vfm_pkg::cmd_t cmd
);
    import vfm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.take_beat = in_valid;
                if (in_valid && final_item)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_i = 1'b1;
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                cmd.capture_cur = 1'b1;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last_j)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.seen || sts.out_free)
                begin
                    cmd.emit_freq = !sts.seen;
                    cmd.next_i    = 1'b1;
                    if (sts.last_i)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_MEAN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_MEAN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_mean = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/vfm_dp.sv -----
module vfm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vfm_pkg::cmd_t                       cmd,
    output vfm_pkg::sts_t                       sts,
    input  logic signed [vfm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                is_mean,
    output logic signed [vfm_pkg::SAMPLE_W-1:0] distinct_value,
    output logic        [vfm_pkg::OCC_W-1:0]    occurrences,
    output logic signed [vfm_pkg::SAMPLE_W-1:0] average,
    output logic                                dropped,
    output logic                                end_of_run
);
    import vfm_pkg::*;

    logic        [CNT_W-1:0]     count_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic                        ovf_reg;
    logic        [CNT_W-1:0]     i_reg;
    logic        [CNT_W-1:0]     j_reg;
    logic        [SAMPLE_W-1:0]  cur_reg;
    logic        [CNT_W-1:0]     occ_reg;
    logic                        seen_reg;
    logic        [CNT_W-1:0]     rem_reg;
    logic        [SUM_W-1:0]     quo_reg;
    logic                        neg_reg;
    logic        [DIV_CNT_W-1:0] dcnt_reg;

    logic                        out_valid_reg;
    logic                        is_mean_reg;
    logic        [SAMPLE_W-1:0]  value_reg;
    logic        [CNT_W-1:0]     occ_out_reg;
    logic        [SAMPLE_W-1:0]  avg_reg;
    logic                        drop_reg;
    logic                        eor_reg;

    logic                        ram_we;
    logic        [CNT_W-1:0]     rd_sel;
    logic        [SAMPLE_W-1:0]  rdata;
    logic        [CNT_W-1:0]     j_plus;
    logic        [CNT_W-1:0]     i_plus;
    logic                        match;
    logic        [SUM_W-1:0]     sum_mag;
    logic        [CNT_W:0]       rem_shift;
    logic        [CNT_W:0]       divisor;
    logic                        rem_ge;
    logic        [SUM_W-1:0]     quo_signed;

    assign j_plus  = j_reg + CNT_W'(1);
    assign i_plus  = i_reg + CNT_W'(1);
    assign match   = (rdata == cur_reg);
    assign ram_we  = cmd.take_beat && !sts.full;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // restoring divide, one quotient bit per cycle
    assign rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
    assign divisor    = {1'b0, count_reg};
    assign rem_ge     = (rem_shift >= divisor);
    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    always_comb
    begin
        rd_sel = j_plus;
        if (cmd.load_i)
        begin
            rd_sel = i_reg;
        end
        else if (cmd.capture_cur)
        begin
            rd_sel = '0;
        end
    end

    vfm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_VALUES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (sample),
        .raddr (rd_sel[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.full     = (count_reg == CNT_W'(MAX_VALUES));
        sts.last_j   = (j_plus == count_reg);
        sts.last_i   = (i_plus == count_reg);
        sts.seen     = seen_reg;
        sts.out_free = !out_valid_reg || !out_stall;
        sts.div_done = (dcnt_reg == DIV_CNT_W'(SUM_W));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            occ_reg       <= '0;
            seen_reg      <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_beat)
            begin
                if (sts.full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    sum_reg   <= sum_reg + SUM_W'(sample);
                end
            end

            if (cmd.capture_cur)
            begin
                j_reg    <= '0;
                occ_reg  <= '0;
                seen_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                j_reg <= j_plus;
                if (match)
                begin
                    occ_reg <= occ_reg + CNT_W'(1);
                    if (j_reg < i_reg)
                    begin
                        seen_reg <= 1'b1;
                    end
                end
            end

            if (cmd.next_i)
            begin
                i_reg <= i_plus;
            end

            if (cmd.div_start)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            end

            if (cmd.emit_mean)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
                i_reg     <= '0;
            end

            if (cmd.emit_freq || cmd.emit_mean)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_cur)
        begin
            cur_reg <= rdata;
        end

        if (cmd.div_start)
        begin
            quo_reg <= sum_mag;
            rem_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? CNT_W'(rem_shift - divisor) : CNT_W'(rem_shift);
        end

        if (cmd.emit_freq)
        begin
            is_mean_reg <= 1'b0;
            value_reg   <= cur_reg;
            occ_out_reg <= occ_reg;
            avg_reg     <= '0;
            drop_reg    <= 1'b0;
            eor_reg     <= 1'b0;
        end
        else if (cmd.emit_mean)
        begin
            is_mean_reg <= 1'b1;
            value_reg   <= '0;
            occ_out_reg <= '0;
            avg_reg     <= quo_signed[SAMPLE_W-1:0];
            drop_reg    <= ovf_reg;
            eor_reg     <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_mean        = is_mean_reg;
    assign distinct_value = value_reg;
    assign occurrences    = OCC_W'(occ_out_reg);
    assign average        = avg_reg;
    assign dropped        = drop_reg;
    assign end_of_run     = eor_reg;

endmodule

// ----- rtl/core/vfm_checker.sv -----
module vfm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                final_item,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                is_mean,
    input logic signed [vfm_pkg::SAMPLE_W-1:0] distinct_value,
    input logic        [vfm_pkg::OCC_W-1:0]    occurrences,
    input logic signed [vfm_pkg::SAMPLE_W-1:0] average,
    input logic                                dropped,
    input logic                                end_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(average) && $stable(distinct_value)
            && $stable(occurrences) && $stable(is_mean))
        else $error("output payload changed while stalled");

    a_busy_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && final_item |=> in_stall)
        else $error("input taken during result walk");

    a_mean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_mean == end_of_run)
            && (is_mean || (average == 0 && !dropped))
            && (!is_mean || (distinct_value == 0 && occurrences == 0)))
        else $error("result fields inconsistent with result kind");

    a_freq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_mean |-> occurrences != 0)
        else $error("frequency beat with zero occurrences");

endmodule

bind value_frequency_and_mean_unit vfm_checker u_vfm_checker (.*);
